[rtl/shape_table_hit_tester_unit_defines.svh]
// Assertion macros for the shape table hit tester.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef SHAPE_TABLE_HIT_TESTER_UNIT_DEFINES_SVH
`define SHAPE_TABLE_HIT_TESTER_UNIT_DEFINES_SVH

// same-cycle implication
`define STHU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STHU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sth_pkg.sv]
// Shared types, codes and micro-step tables of the shape table hit tester.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package sth_pkg;

    localparam int MAX_SHAPES_DEF = 64;
    localparam int COORD_BITS     = 16;
    localparam int KIND_W         = 2;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_PICK   = 3'd1;
    localparam logic [2:0] OP_MOVE   = 3'd2;
    localparam logic [2:0] OP_RESIZE = 3'd3;
    localparam logic [2:0] OP_CORNER = 3'd4;

    localparam logic [1:0] KIND_ELLIPSE = 2'd0;
    localparam logic [1:0] KIND_RECT    = 2'd1;
    localparam logic [1:0] KIND_SEGMENT = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

    localparam logic [2:0] CORNER_NONE = 3'd0;
    localparam logic [2:0] CORNER_UL   = 3'd1;
    localparam logic [2:0] CORNER_LL   = 3'd4;

    localparam logic CFG_SEG_TOL    = 1'b0;
    localparam logic CFG_CORNER_RAD = 1'b1;

    localparam logic [7:0] SEG_TOL_RESET    = 8'd5;
    localparam logic [7:0] CORNER_RAD_RESET = 8'd7;

    // shared multiplier: 36 x 18 unsigned, signed accumulate
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 72;
    localparam int OPND_W  = 37;

    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] ELL_LAST       = 4'd8;
    localparam logic [3:0] SEG_BRANCH     = 4'd3;
    localparam logic [3:0] SEG_PROJ_FIRST = 4'd4;
    localparam logic [3:0] SEG_PROJ_LAST  = 4'd10;
    localparam logic [3:0] SEG_END_FIRST  = 4'd11;
    localparam logic [3:0] SEG_END_LAST   = 4'd14;
    localparam logic [3:0] CRN_LAST       = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_LOAD,
        ST_TEST,
        ST_CALC,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        SRC_U, SRC_V, SRC_W, SRC_BH,
        SRC_SPX, SRC_SPY, SRC_SEX, SRC_SEY, SRC_EPX, SRC_EPY,
        SRC_DX, SRC_DY, SRC_RAD, SRC_TT1,
        SRC_S0, SRC_S1, SRC_S2
    } src_t;

    typedef enum logic [1:0] {
        SAVE_NONE,
        SAVE_S0,
        SAVE_S1,
        SAVE_S2
    } save_t;

    typedef struct packed {
        src_t  a_sel;
        src_t  b_sel;
        logic  b_hi;
        logic  sub;
        logic  clr;
        save_t save;
    } ustep_t;

    function automatic ustep_t mk_step(input src_t a, input src_t b, input logic hi,
                                       input logic sub, input logic clr, input save_t sv);
        ustep_t u;
        u.a_sel = a;
        u.b_sel = b;
        u.b_hi  = hi;
        u.sub   = sub;
        u.clr   = clr;
        u.save  = sv;
        return u;
    endfunction

    // U^2 B^2 + V^2 W^2 - W^2 B^2 as (UB)^2 + (VW)^2 - (WB)^2
    function automatic ustep_t ell_step(input logic [3:0] s);
        ustep_t u;
        case (s)
            4'd0:    u = mk_step(SRC_U,  SRC_BH, 1'b0, 1'b0, 1'b1, SAVE_S0);
            4'd1:    u = mk_step(SRC_V,  SRC_W,  1'b0, 1'b0, 1'b1, SAVE_S1);
            4'd2:    u = mk_step(SRC_W,  SRC_BH, 1'b0, 1'b0, 1'b1, SAVE_S2);
            4'd3:    u = mk_step(SRC_S0, SRC_S0, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd4:    u = mk_step(SRC_S0, SRC_S0, 1'b1, 1'b0, 1'b0, SAVE_NONE);
            4'd5:    u = mk_step(SRC_S1, SRC_S1, 1'b0, 1'b0, 1'b0, SAVE_NONE);
            4'd6:    u = mk_step(SRC_S1, SRC_S1, 1'b1, 1'b0, 1'b0, SAVE_NONE);
            4'd7:    u = mk_step(SRC_S2, SRC_S2, 1'b0, 1'b1, 1'b0, SAVE_NONE);
            4'd8:    u = mk_step(SRC_S2, SRC_S2, 1'b1, 1'b1, 1'b0, SAVE_NONE);
            default: u = mk_step(SRC_U,  SRC_BH, 1'b0, 1'b0, 1'b1, SAVE_NONE);
        endcase
        return u;
    endfunction

    // dot products, then cross^2 - (T*T+1)*len or the endpoint distances
    function automatic ustep_t seg_step(input logic [3:0] s);
        ustep_t u;
        case (s)
            4'd0:    u = mk_step(SRC_SPX, SRC_SEX, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd1:    u = mk_step(SRC_SPY, SRC_SEY, 1'b0, 1'b0, 1'b0, SAVE_S0);
            4'd2:    u = mk_step(SRC_EPX, SRC_SEX, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd3:    u = mk_step(SRC_EPY, SRC_SEY, 1'b0, 1'b0, 1'b0, SAVE_S1);
            4'd4:    u = mk_step(SRC_SPX, SRC_SEY, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd5:    u = mk_step(SRC_SPY, SRC_SEX, 1'b0, 1'b1, 1'b0, SAVE_S2);
            4'd6:    u = mk_step(SRC_SEX, SRC_SEX, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd7:    u = mk_step(SRC_SEY, SRC_SEY, 1'b0, 1'b0, 1'b0, SAVE_S0);
            4'd8:    u = mk_step(SRC_S2,  SRC_S2,  1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd9:    u = mk_step(SRC_S2,  SRC_S2,  1'b1, 1'b0, 1'b0, SAVE_NONE);
            4'd10:   u = mk_step(SRC_S0,  SRC_TT1, 1'b0, 1'b1, 1'b0, SAVE_NONE);
            4'd11:   u = mk_step(SRC_SPX, SRC_SPX, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd12:   u = mk_step(SRC_SPY, SRC_SPY, 1'b0, 1'b0, 1'b0, SAVE_S2);
            4'd13:   u = mk_step(SRC_EPX, SRC_EPX, 1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd14:   u = mk_step(SRC_EPY, SRC_EPY, 1'b0, 1'b0, 1'b0, SAVE_NONE);
            default: u = mk_step(SRC_SPX, SRC_SEX, 1'b0, 1'b0, 1'b1, SAVE_NONE);
        endcase
        return u;
    endfunction

    // dx^2 + dy^2 - r^2
    function automatic ustep_t crn_step(input logic [3:0] s);
        ustep_t u;
        case (s)
            4'd0:    u = mk_step(SRC_DX,  SRC_DX,  1'b0, 1'b0, 1'b1, SAVE_NONE);
            4'd1:    u = mk_step(SRC_DY,  SRC_DY,  1'b0, 1'b0, 1'b0, SAVE_NONE);
            4'd2:    u = mk_step(SRC_RAD, SRC_RAD, 1'b0, 1'b1, 1'b0, SAVE_NONE);
            default: u = mk_step(SRC_DX,  SRC_DX,  1'b0, 1'b0, 1'b1, SAVE_NONE);
        endcase
        return u;
    endfunction

endpackage

[rtl/sth_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/shape_table_hit_tester_unit.sv]
// Shape table hit tester: shape table in RAM, one shared 36x18 multiplier under a sequencer.
// Depends on sth_pkg and sth_ram.
// One item at a time. Pick tests the entries in turn, rectangles and vertical or horizontal
// segments directly, ellipses and slanted segments via products; each product is registered
// in the multiplier before it is accumulated. Corner query tests the corners in turn.
// Next item accepted the cycle after the result loads. Async active-low reset empties the
// table and restores tolerance 5, radius 7.
`timescale 1ns / 1ps

module shape_table_hit_tester_unit
    import sth_pkg::*;
#(
    parameter int MAX_SHAPES = MAX_SHAPES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [2:0]                   opcode,
    input  logic [1:0]                   shape_type,
    input  logic [5:0]                   entry_index,
    input  logic signed [COORD_BITS-1:0] x0,
    input  logic signed [COORD_BITS-1:0] y0,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         hit_found,
    output logic [5:0]                   hit_index,
    output logic [2:0]                   near_corner,
    output logic [1:0]                   status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [7:0]                   cfg_data
);

    localparam int IDX_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CNT_W = $clog2(MAX_SHAPES + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam int ENT_W = KIND_W + 4 * COORD_BITS;
    localparam int C     = COORD_BITS;

    state_t state_reg, state_next;

    logic [2:0]           op_reg;
    logic [1:0]           kind_reg;
    logic [5:0]           idx_reg;
    logic signed [C-1:0]  px_reg, py_reg, qx_reg, qy_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [7:0]       tol_reg, rad_reg;
    logic [15:0]      tt_reg;

    logic [1:0]          ent_kind_reg;
    logic signed [C-1:0] ent_l_reg, ent_t_reg, ent_r_reg, ent_b_reg;

    logic [3:0] step_reg, step_next;
    logic       phase_reg, phase_next;
    logic [1:0] crn_reg, crn_next;

    logic [PROD_W-1:0] prod_reg;
    logic              pneg_reg, phi_reg, pclr_reg;
    save_t             psave_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [OPND_W-1:0] s0_reg, s1_reg, s2_reg;

    logic       res_found_reg, res_found_next;
    logic [5:0] res_idx_reg, res_idx_next;
    logic [2:0] res_corner_reg, res_corner_next;
    logic [1:0] res_status_reg, res_status_next;

    logic       rsp_valid_reg;
    logic       out_found_reg;
    logic [5:0] out_idx_reg;
    logic [2:0] out_corner_reg;
    logic [1:0] out_status_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;

    logic accept, used, out_load;

    // geometry
    logic signed [C:0]   w_d, d_tb, bh, spx, spy, sey, epx, epy, dx, dy;
    logic signed [C+2:0] u_v;
    logic signed [C+1:0] v_v, tol_s;
    logic signed [C-1:0] cx, cy, seg_lo, seg_hi;
    logic [C:0]          tt1;
    logic                rect_hit, vert_hit, horiz_hit, ell_degen, quick_hit, needs_calc;

    // shared unit
    ustep_t               cur;
    logic [OPND_W-1:0]    a_val, b_val, a_abs, b_abs, s2_abs;
    logic [MUL_B_W-1:0]   b_chunk;
    logic [PROD_W-1:0]    prod_next;
    logic [ACC_W-1:0]     acc_base, acc_ext;
    logic                 acc_neg, acc_zero, proj, cp_small, end_hit;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign used      = CMP_W'(idx_reg) < CMP_W'(cnt_reg);
    assign out_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid   = rsp_valid_reg;
    assign hit_found   = out_found_reg;
    assign hit_index   = out_idx_reg;
    assign near_corner = out_corner_reg;
    assign status      = out_status_reg;

    sth_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SHAPES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        w_d    = ent_r_reg - ent_l_reg;
        d_tb   = ent_b_reg - ent_t_reg;
        bh     = $signed(d_tb + {{C{1'b0}}, d_tb[C]}) >>> 1;
        u_v    = $signed({px_reg, 1'b0}) - $signed({ent_l_reg, 1'b0}) - w_d;
        v_v    = py_reg - ent_t_reg - bh;
        spx    = px_reg - ent_l_reg;
        spy    = py_reg - ent_t_reg;
        sey    = d_tb;
        epx    = px_reg - ent_r_reg;
        epy    = py_reg - ent_b_reg;
        cx     = (crn_reg == 2'd0 || crn_reg == 2'd3) ? ent_l_reg : ent_r_reg;
        cy     = (crn_reg == 2'd0 || crn_reg == 2'd1) ? ent_t_reg : ent_b_reg;
        dx     = px_reg - cx;
        dy     = py_reg - cy;
        tt1    = {1'b0, tt_reg} + (C+1)'(1);
        tol_s  = {{(C-6){1'b0}}, tol_reg};
        seg_lo = 'x;
        seg_hi = 'x;

        rect_hit = px_reg >= ent_l_reg && px_reg <= ent_r_reg
                && py_reg >= ent_t_reg && py_reg <= ent_b_reg;

        seg_lo   = (ent_t_reg < ent_b_reg) ? ent_t_reg : ent_b_reg;
        seg_hi   = (ent_t_reg < ent_b_reg) ? ent_b_reg : ent_t_reg;
        vert_hit = px_reg <= ent_l_reg + tol_s && px_reg >= ent_l_reg - tol_s
                && py_reg >= seg_lo - tol_s && py_reg <= seg_hi + tol_s;
        if (ent_l_reg != ent_r_reg)
        begin
            seg_lo = (ent_l_reg < ent_r_reg) ? ent_l_reg : ent_r_reg;
            seg_hi = (ent_l_reg < ent_r_reg) ? ent_r_reg : ent_l_reg;
        end
        horiz_hit = py_reg <= ent_t_reg + tol_s && py_reg >= ent_t_reg - tol_s
                 && px_reg >= seg_lo - tol_s && px_reg <= seg_hi + tol_s;

        ell_degen = (w_d == '0) || (bh == '0);

        quick_hit  = 1'b0;
        needs_calc = 1'b0;
        case (ent_kind_reg)
            KIND_ELLIPSE: needs_calc = !ell_degen;
            KIND_RECT:    quick_hit  = rect_hit;
            KIND_SEGMENT:
            begin
                if (ent_l_reg == ent_r_reg)
                begin
                    quick_hit = vert_hit;
                end
                else if (ent_t_reg == ent_b_reg)
                begin
                    quick_hit = horiz_hit;
                end
                else
                begin
                    needs_calc = 1'b1;
                end
            end
            default: quick_hit = 1'b0;
        endcase
    end

    function automatic logic [OPND_W-1:0] src_mux(input src_t s);
        logic [OPND_W-1:0] r;
        case (s)
            SRC_U:   r = OPND_W'(u_v);
            SRC_V:   r = OPND_W'(v_v);
            SRC_W:   r = OPND_W'(w_d);
            SRC_BH:  r = OPND_W'(bh);
            SRC_SPX: r = OPND_W'(spx);
            SRC_SPY: r = OPND_W'(spy);
            SRC_SEX: r = OPND_W'(w_d);
            SRC_SEY: r = OPND_W'(sey);
            SRC_EPX: r = OPND_W'(epx);
            SRC_EPY: r = OPND_W'(epy);
            SRC_DX:  r = OPND_W'(dx);
            SRC_DY:  r = OPND_W'(dy);
            SRC_RAD: r = OPND_W'(rad_reg);
            SRC_TT1: r = OPND_W'(tt1);
            SRC_S0:  r = s0_reg;
            SRC_S1:  r = s1_reg;
            SRC_S2:  r = s2_reg;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        if (op_reg == OP_CORNER)
        begin
            cur = crn_step(step_reg);
        end
        else if (ent_kind_reg == KIND_ELLIPSE)
        begin
            cur = ell_step(step_reg);
        end
        else
        begin
            cur = seg_step(step_reg);
        end

        a_val     = src_mux(cur.a_sel);
        b_val     = src_mux(cur.b_sel);
        a_abs     = a_val[OPND_W-1] ? (~a_val + OPND_W'(1)) : a_val;
        b_abs     = b_val[OPND_W-1] ? (~b_val + OPND_W'(1)) : b_val;
        b_chunk   = cur.b_hi ? b_abs[2*MUL_B_W-1:MUL_B_W] : b_abs[MUL_B_W-1:0];
        prod_next = PROD_W'(a_abs[MUL_A_W-1:0]) * PROD_W'(b_chunk);

        acc_base = pclr_reg ? '0 : acc_reg;
        acc_ext  = ACC_W'(prod_reg) << (phi_reg ? MUL_B_W : 0);
        acc_next = pneg_reg ? (acc_base - acc_ext) : (acc_base + acc_ext);
        acc_neg  = acc_next[ACC_W-1];
        acc_zero = (acc_next == '0);

        s2_abs   = s2_reg[OPND_W-1] ? (~s2_reg + OPND_W'(1)) : s2_reg;
        proj     = (s0_reg == '0) || acc_zero || (s0_reg[OPND_W-1] != acc_neg);
        cp_small = (s2_abs[OPND_W-1:32] == '0);
        end_hit  = (s2_reg <= OPND_W'(tt_reg)) || (acc_next <= ACC_W'(tt_reg));
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        crn_next        = crn_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        res_corner_next = res_corner_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = {ent_kind_reg, px_reg, py_reg, qx_reg, qy_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    res_corner_next = CORNER_NONE;
                    res_status_next = STAT_OK;
                    state_next      = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (cnt_reg >= CNT_W'(MAX_SHAPES))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            ram_waddr    = IDX_W'(cnt_reg);
                            ram_wdata    = {kind_reg, px_reg, py_reg, qx_reg, qy_reg};
                            cnt_next     = cnt_reg + CNT_W'(1);
                            res_idx_next = 6'(cnt_reg);
                        end
                    end
                    OP_PICK:
                    begin
                        if (cnt_reg != '0)
                        begin
                            addr_next  = '0;
                            state_next = ST_READ;
                        end
                    end
                    OP_MOVE, OP_RESIZE, OP_CORNER:
                    begin
                        if (!used)
                        begin
                            res_status_next = STAT_BAD_INDEX;
                        end
                        else
                        begin
                            addr_next  = IDX_W'(idx_reg);
                            state_next = ST_READ;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_TEST;
            ST_TEST:
            begin
                step_next  = STEP_FIRST;
                phase_next = 1'b0;
                crn_next   = '0;
                case (op_reg)
                    OP_PICK:
                    begin
                        if (needs_calc)
                        begin
                            state_next = ST_CALC;
                        end
                        else
                        begin
                            if (quick_hit)
                            begin
                                res_found_next = 1'b1;
                                res_idx_next   = 6'(addr_reg);
                            end
                            state_next = ST_NEXT;
                        end
                    end
                    OP_MOVE:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {ent_kind_reg,
                                      C'(ent_l_reg + px_reg), C'(ent_t_reg + py_reg),
                                      C'(ent_r_reg + px_reg), C'(ent_b_reg + py_reg)};
                        state_next = ST_DONE;
                    end
                    OP_RESIZE:
                    begin
                        ram_we     = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_CORNER: state_next = ST_CALC;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_CALC:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    step_next = step_reg + 4'd1;
                    if (op_reg == OP_CORNER)
                    begin
                        if (step_reg == CRN_LAST)
                        begin
                            step_next = STEP_FIRST;
                            if (acc_neg)
                            begin
                                res_corner_next = CORNER_UL + 3'(crn_reg);
                                state_next      = ST_DONE;
                            end
                            else if (crn_reg == 2'd3)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                crn_next = crn_reg + 2'd1;
                            end
                        end
                    end
                    else if (ent_kind_reg == KIND_ELLIPSE)
                    begin
                        if (step_reg == ELL_LAST)
                        begin
                            if (acc_neg || acc_zero)
                            begin
                                res_found_next = 1'b1;
                                res_idx_next   = 6'(addr_reg);
                            end
                            state_next = ST_NEXT;
                        end
                    end
                    else
                    begin
                        if (step_reg == SEG_BRANCH)
                        begin
                            step_next = proj ? SEG_PROJ_FIRST : SEG_END_FIRST;
                        end
                        else if (step_reg == SEG_PROJ_LAST || step_reg == SEG_END_LAST)
                        begin
                            if ((step_reg == SEG_PROJ_LAST) ? (acc_neg && cp_small) : end_hit)
                            begin
                                res_found_next = 1'b1;
                                res_idx_next   = 6'(addr_reg);
                            end
                            state_next = ST_NEXT;
                        end
                    end
                end
            end
            ST_NEXT:
            begin
                if (CNT_W'(addr_reg) + CNT_W'(1) == cnt_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next  = addr_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            addr_reg       <= '0;
            step_reg       <= STEP_FIRST;
            phase_reg      <= 1'b0;
            crn_reg        <= '0;
            tol_reg        <= SEG_TOL_RESET;
            rad_reg        <= CORNER_RAD_RESET;
            tt_reg         <= 16'(SEG_TOL_RESET) * 16'(SEG_TOL_RESET);
            rsp_valid_reg  <= 1'b0;
            res_found_reg  <= 1'b0;
            res_idx_reg    <= '0;
            res_corner_reg <= CORNER_NONE;
            res_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            addr_reg       <= addr_next;
            step_reg       <= step_next;
            phase_reg      <= phase_next;
            crn_reg        <= crn_next;
            tt_reg         <= 16'(tol_reg) * 16'(tol_reg);
            res_found_reg  <= res_found_next;
            res_idx_reg    <= res_idx_next;
            res_corner_reg <= res_corner_next;
            res_status_reg <= res_status_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SEG_TOL:    tol_reg <= cfg_data;
                    CFG_CORNER_RAD: rad_reg <= cfg_data;
                    default:        tol_reg <= tol_reg;
                endcase
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            kind_reg <= shape_type;
            idx_reg  <= entry_index;
            px_reg   <= x0;
            py_reg   <= y0;
            qx_reg   <= x1;
            qy_reg   <= y1;
        end
        if (state_reg == ST_LOAD)
        begin
            ent_kind_reg <= ram_rdata[ENT_W-1 -: KIND_W];
            ent_l_reg    <= $signed(ram_rdata[4*C-1 -: C]);
            ent_t_reg    <= $signed(ram_rdata[3*C-1 -: C]);
            ent_r_reg    <= $signed(ram_rdata[2*C-1 -: C]);
            ent_b_reg    <= $signed(ram_rdata[C-1:0]);
        end
        if (state_reg == ST_CALC)
        begin
            if (!phase_reg)
            begin
                prod_reg  <= prod_next;
                pneg_reg  <= a_val[OPND_W-1] ^ b_val[OPND_W-1] ^ cur.sub;
                phi_reg   <= cur.b_hi;
                pclr_reg  <= cur.clr;
                psave_reg <= cur.save;
            end
            else
            begin
                acc_reg <= acc_next;
                case (psave_reg)
                    SAVE_S0: s0_reg <= acc_next[OPND_W-1:0];
                    SAVE_S1: s1_reg <= acc_next[OPND_W-1:0];
                    SAVE_S2: s2_reg <= acc_next[OPND_W-1:0];
                    default: ;
                endcase
            end
        end
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_idx_reg    <= res_idx_reg;
            out_corner_reg <= res_corner_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

[rtl/sth_checker.sv]
// Port-level checker for the shape table hit tester, bound to the top level.
// Depends on sth_pkg and shape_table_hit_tester_unit_defines.svh.
`timescale 1ns / 1ps
`include "shape_table_hit_tester_unit_defines.svh"

module sth_checker
    import sth_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_stall,
    input logic [2:0]                   opcode,
    input logic [1:0]                   shape_type,
    input logic [5:0]                   entry_index,
    input logic signed [COORD_BITS-1:0] x0,
    input logic signed [COORD_BITS-1:0] y0,
    input logic signed [COORD_BITS-1:0] x1,
    input logic signed [COORD_BITS-1:0] y1,
    input logic                         rsp_valid,
    input logic                         rsp_stall,
    input logic                         hit_found,
    input logic [5:0]                   hit_index,
    input logic [2:0]                   near_corner,
    input logic [1:0]                   status,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         cfg_index,
    input logic [7:0]                   cfg_data
);

    `STHU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(hit_found) && $stable(hit_index) && $stable(near_corner) && $stable(status), "stalled result item changed")
    `STHU_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "not busy after item accept")
    `STHU_ASSERT_SAME(a_full_clean, rsp_valid && status == STAT_FULL, !hit_found && hit_index == '0 && near_corner == CORNER_NONE, "table full result carries data")
    `STHU_ASSERT_SAME(a_hit_clean, rsp_valid && hit_found, status == STAT_OK && near_corner == CORNER_NONE, "pick hit with corner or error")

endmodule

bind shape_table_hit_tester_unit sth_checker u_sth_checker (.*);
